>>> rtl/lepd_pkg.sv
// Shared constants and payload types for the Laplacian edge point detector.
`default_nettype none

package lepd_pkg;

   // Frame geometry
   localparam int FRAME_WIDTH  = 160;
   localparam int FRAME_HEIGHT = 120;

   // Field widths
   localparam int PIXEL_WIDTH     = 8;
   localparam int COL_WIDTH       = 8;
   localparam int ROW_WIDTH       = 7;
   localparam int STRENGTH_WIDTH  = 10;
   localparam int THRESHOLD_WIDTH = 10;

   // Line store addressing
   localparam int COL_ADDR_WIDTH = $clog2(FRAME_WIDTH);

   // Laplacian datapath: signed, wide enough for -1020..1020 plus margin
   localparam int RESP_WIDTH = PIXEL_WIDTH + 4;

   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = THRESHOLD_WIDTH'(180);

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [COL_WIDTH-1:0]      edge_column;
      logic [ROW_WIDTH-1:0]      edge_row;
      logic [STRENGTH_WIDTH-1:0] edge_strength;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/laplacian_edge_point_detector_core.sv
// Top level: 4-neighbour Laplacian edge point detector on a raster pixel stream.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  lepd_pkg::req_payload_type (pixel, frame_start)
//   rsp      out        rsp_valid/rsp_stall  lepd_pkg::rsp_payload_type (column, row, strength)
//   csr      in         csr_wr_en            csr_wr_data = edge_threshold
//
// One pixel per clock sustained while the result side does not stall. A transaction is
// accepted, its column of the line stores is read on that edge, and the next cycle
// computes the response; the stores are written back as the result register loads.
// Reset (synchronous, active high) clears counters, valids and sets threshold to 180.
// The line stores have no reset. A stalled result holds the compute stage, which
// in turn stalls the request side; no transaction is dropped.
`default_nettype none

module laplacian_edge_point_detector_core (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire lepd_pkg::req_payload_type                req_payload,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output lepd_pkg::rsp_payload_type                     rsp_payload,
   input  wire logic                                     csr_wr_en,
   input  wire logic [lepd_pkg::THRESHOLD_WIDTH-1:0]     csr_wr_data
);

   localparam int PW = lepd_pkg::PIXEL_WIDTH;
   localparam int CW = lepd_pkg::COL_WIDTH;
   localparam int RW = lepd_pkg::ROW_WIDTH;
   localparam int AW = lepd_pkg::COL_ADDR_WIDTH;
   localparam int XW = lepd_pkg::RESP_WIDTH;
   localparam int TW = lepd_pkg::THRESHOLD_WIDTH;
   localparam int SW = lepd_pkg::STRENGTH_WIDTH;

   localparam logic [CW-1:0] LAST_COL = CW'(lepd_pkg::FRAME_WIDTH - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(lepd_pkg::FRAME_HEIGHT - 1);

   // Threshold register
   logic [TW-1:0] threshold_ff;

   // Position of the next pixel
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Compute stage
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          fwd_c_ff, fwd_c_in;
   logic          fwd_r_ff, fwd_r_in;
   logic [PW-1:0] fwd_upper_ff;
   logic [PW-1:0] fwd_mid_ff;
   logic [PW-1:0] left_hold_ff;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   lepd_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic          accept;
   logic          s1_go;
   logic [CW-1:0] acc_col;
   logic [RW-1:0] acc_row;
   logic          acc_last_col;
   logic [CW-1:0] right_col;

   logic [2*PW-1:0] line_rd;
   logic [PW-1:0]   upper_rd, mid_c_rd, mid_r_rd;
   logic [PW-1:0]   up_pix, centre_pix, right_pix;
   logic [XW-1:0]   resp;
   logic            interior;
   logic            hit;

   // Handshake: compute stage advances whenever the result register can take it
   assign s1_go     = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_go;
   assign accept    = req_valid & ~req_stall;

   // Position of the accepted pixel
   assign acc_col      = req_payload.frame_start ? '0 : col_ff;
   assign acc_row      = req_payload.frame_start ? '0 : row_ff;
   assign acc_last_col = (acc_col == LAST_COL);
   assign right_col    = acc_last_col ? '0 : acc_col + CW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (acc_last_col) begin
            col_in = '0;
            row_in = (acc_row == LAST_ROW) ? '0 : acc_row + RW'(1);
         end else begin
            col_in = acc_col + CW'(1);
            row_in = acc_row;
         end
      end
   end

   // Same-edge write/read collisions are forwarded from the compute stage
   assign fwd_c_in = s1_go & (s1_col_ff == acc_col);
   assign fwd_r_in = s1_go & (s1_col_ff == right_col);

   // Line stores: upper and middle share one word per column; a middle copy serves
   // the right-neighbor read
   lepd_ram #(.DATA_WIDTH(2 * PW), .DEPTH(lepd_pkg::FRAME_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (AW'(s1_col_ff)),
      .wr_data ({centre_pix, s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (AW'(acc_col)),
      .rd_data (line_rd)
   );

   assign {upper_rd, mid_c_rd} = line_rd;

   lepd_ram #(.DATA_WIDTH(PW), .DEPTH(lepd_pkg::FRAME_WIDTH)) u_mid_r_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (AW'(s1_col_ff)),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (AW'(right_col)),
      .rd_data (mid_r_rd)
   );

   // Neighborhood after forwarding
   assign up_pix     = fwd_c_ff ? fwd_upper_ff : upper_rd;
   assign centre_pix = fwd_c_ff ? fwd_mid_ff   : mid_c_rd;
   assign right_pix  = fwd_r_ff ? fwd_mid_ff   : mid_r_rd;

   // Laplacian: up + left + right + down - 4*centre
   assign resp = XW'(up_pix) + XW'(left_hold_ff) + XW'(right_pix) + XW'(s1_pix_ff)
               - (XW'(centre_pix) << 2);

   assign interior = (s1_row_ff >= RW'(2)) && (s1_col_ff != '0) && (s1_col_ff != LAST_COL);
   assign hit      = interior && ($signed(resp) > $signed(XW'(threshold_ff)));

   always_comb begin
      rsp_payload_in.edge_column   = s1_col_ff;
      rsp_payload_in.edge_row      = s1_row_ff - RW'(1);
      rsp_payload_in.edge_strength = resp[SW-1:0];
   end

   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_go);
   assign rsp_valid_in = s1_go ? hit : (rsp_valid_ff & rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lepd_pkg::THRESHOLD_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_hold_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            left_hold_ff <= centre_pix;
         end
      end
   end

   // Compute stage payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= req_payload.pixel;
         s1_col_ff    <= acc_col;
         s1_row_ff    <= acc_row;
         fwd_c_ff     <= fwd_c_in;
         fwd_r_ff     <= fwd_r_in;
         fwd_upper_ff <= centre_pix;
         fwd_mid_ff   <= s1_pix_ff;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

>>> rtl/lepd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lepd_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 160
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; old data on a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> test/tb_laplacian_edge_point_detector_core.sv
// Self-checking testbench for the 4-neighbour Laplacian edge point detector core.
`default_nettype none

module tb_laplacian_edge_point_detector_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW = lepd_pkg::PIXEL_WIDTH;
   localparam int CW = lepd_pkg::COL_WIDTH;
   localparam int RW = lepd_pkg::ROW_WIDTH;
   localparam int SW = lepd_pkg::STRENGTH_WIDTH;
   localparam int TW = lepd_pkg::THRESHOLD_WIDTH;
   localparam int FW = lepd_pkg::FRAME_WIDTH;
   localparam int FH = lepd_pkg::FRAME_HEIGHT;

   localparam int CENTRE_WEIGHT = 4;
   localparam int SETTLE_CYCLES = 6;      // margin for the pipeline to empty after the queues drain
   localparam int HOLD_CYCLES   = 800;    // long output hold to back the pipe up
   localparam int STUCK_LIMIT   = 4000;   // cycles with work pending but no transaction
   localparam logic [TW-1:0] THRESHOLD_MAX = '1;

   // Pixel content of generated frames
   typedef enum {PAT_PEAK, PAT_PIT, PAT_RANDOM, PAT_SPIKY} pattern_type;

   // DUT signals; the inputs are known from time zero
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   lepd_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   lepd_pkg::rsp_payload_type rsp_payload;
   logic                      csr_wr_en   = 1'b0;
   logic [TW-1:0]             csr_wr_data = '0;

   // Stimulus and scoreboard storage
   lepd_pkg::req_payload_type pending_pixels[$];
   lepd_pkg::rsp_payload_type expected_points[$];

   // Idle percentages and output hold request
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // Predictor state
   logic [PW-1:0] upper_line  [FW];
   logic [PW-1:0] middle_line [FW];
   logic [PW-1:0] left_hold;
   logic [TW-1:0] edge_limit;
   int col_pos;
   int row_pos;

   // Statistics
   int mismatch_count     = 0;
   int points_checked     = 0;
   int pixels_accepted    = 0;
   int thresholds_written = 0;
   int stuck_cycles       = 0;

   laplacian_edge_point_detector_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("ERROR %0t: %s", $realtime, msg);
   endtask

   function automatic void reset_predictor();
      for (int i = 0; i < FW; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      left_hold  = '0;
      col_pos    = 0;
      row_pos    = 0;
      edge_limit = lepd_pkg::THRESHOLD_RESET;
   endfunction

   // Advance the line stores by one pixel and queue the edge point it completes
   function automatic void predict_edge_point(lepd_pkg::req_payload_type item);
      int col;
      int row;
      int resp;
      logic [PW-1:0] centre;
      lepd_pkg::rsp_payload_type point;
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= FW) col_pos = 0;
      if (row_pos >= FH) row_pos = 0;
      col    = col_pos;
      row    = row_pos;
      centre = middle_line[col];
      // interior centre one row up: left comes from the held old middle entry
      if (row >= 2 && col >= 1 && col + 1 < FW) begin
         resp = int'(upper_line[col]) + int'(left_hold) + int'(middle_line[col + 1])
              + int'(item.pixel) - CENTRE_WEIGHT * int'(centre);
         if (resp > int'(edge_limit)) begin
            point.edge_column   = CW'(col);
            point.edge_row      = RW'(row - 1);
            point.edge_strength = SW'(resp);
            expected_points.push_back(point);
         end
      end
      upper_line[col]  = centre;
      middle_line[col] = item.pixel;
      left_hold        = centre;
      col_pos = col + 1;
      if (col_pos >= FW) begin
         col_pos = 0;
         row_pos = row + 1;
         if (row_pos >= FH) row_pos = 0;
      end
   endfunction

   task automatic check_edge_point(lepd_pkg::rsp_payload_type got);
      lepd_pkg::rsp_payload_type want;
      if (expected_points.size() == 0) begin
         report_mismatch($sformatf("unexpected edge point col %0d row %0d strength %0d",
                                   got.edge_column, got.edge_row, got.edge_strength));
         return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (got.edge_column !== want.edge_column)
         report_mismatch($sformatf("edge_column got %0d expected %0d",
                                   got.edge_column, want.edge_column));
      if (got.edge_row !== want.edge_row)
         report_mismatch($sformatf("edge_row got %0d expected %0d (col %0d)",
                                   got.edge_row, want.edge_row, want.edge_column));
      if (got.edge_strength !== want.edge_strength)
         report_mismatch($sformatf("edge_strength got %0d expected %0d (col %0d row %0d)",
                                   got.edge_strength, want.edge_strength,
                                   want.edge_column, want.edge_row));
   endtask

   // Driver: offer the next pending pixel once the previous transaction is gone
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_pixels.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: random idling, or one long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_left   = 0;
         hold_served = hold_token;
      end else if (hold_served != hold_token) begin
         hold_served = hold_token;
         hold_left   = HOLD_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: predict on accepted pixels, check accepted edge points
   always @(posedge clock) begin
      if (reset) begin
         reset_predictor();
      end else begin
         if (csr_wr_en) edge_limit = csr_wr_data;
         if (req_valid && !req_stall) begin
            predict_edge_point(req_payload);
            pixels_accepted++;
         end
         if (rsp_valid && !rsp_stall) check_edge_point(rsp_payload);
      end
   end

   // Watchdog: work outstanding but no transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_pixels.size() == 0 && !req_valid && expected_points.size() == 0)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic void queue_pixel(logic [PW-1:0] value, logic start);
      lepd_pkg::req_payload_type item;
      item.pixel       = value;
      item.frame_start = start;
      pending_pixels.push_back(item);
   endfunction

   function automatic logic [PW-1:0] pixel_for(pattern_type kind, int row, int col);
      logic [PW-1:0] peak;
      // peak: bright rows around odd-row dark dots, response 1020 at each dot
      peak = (row % 2 == 1 && col % 2 == 1) ? 8'd0 : 8'd255;
      case (kind)
         PAT_PEAK:   return peak;
         PAT_PIT:    return ~peak;
         PAT_RANDOM: return PW'($urandom_range(255));
         default: begin
            // flat background with sparse dark or bright spikes
            if ($urandom_range(19) == 0) return $urandom_range(1) ? 8'd0 : 8'd255;
            return PW'(96 + $urandom_range(7));
         end
      endcase
   endfunction

   // Pixels first .. first+count-1 of a frame in raster order
   function automatic void push_frame(pattern_type kind, int first, int count,
                                      logic with_start);
      for (int i = first; i < first + count; i++) begin
         queue_pixel(pixel_for(kind, i / FW, i % FW), with_start && i == first);
      end
   endfunction

   // Random pixels with the occasional stray frame start
   function automatic void push_noise(int count);
      for (int i = 0; i < count; i++) begin
         queue_pixel(PW'($urandom_range(255)), $urandom_range(39) == 0);
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_points.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [TW-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thresholds_written++;
   endtask

   // Test sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sender idles lightly, receiver heavily; reset threshold in force
      send_idle_pct = 35;
      recv_idle_pct = 81;
      queue_pixel(8'h00, 1'b1);
      queue_pixel(8'hFF, 1'b0);
      queue_pixel(8'h55, 1'b0);
      queue_pixel(8'hAA, 1'b0);
      queue_pixel(8'h01, 1'b0);
      queue_pixel(8'h80, 1'b0);
      queue_pixel(8'hFE, 1'b0);
      queue_pixel(8'h7F, 1'b1);
      queue_pixel(8'hFF, 1'b1);
      queue_pixel(8'h00, 1'b0);
      queue_pixel(8'h0F, 1'b0);
      queue_pixel(8'hF0, 1'b1);
      queue_pixel(8'h3C, 1'b0);
      queue_pixel(8'hC3, 1'b0);
      // two rows fill the line stores, then the dots answer at full strength
      push_frame(PAT_PEAK, 0, 2 * FW + 30, 1'b1);
      wait_drained();

      // Just below and exactly at the strongest response, same frame going on
      write_threshold(TW'(1019));
      push_frame(PAT_PEAK, 2 * FW + 30, 30, 1'b0);
      wait_drained();
      write_threshold(TW'(1020));
      push_frame(PAT_PEAK, 2 * FW + 60, 30, 1'b0);
      wait_drained();

      // Roles swapped: receiver idles lightly, sender heavily
      send_idle_pct = 81;
      recv_idle_pct = 35;
      // lowest threshold across the end of a row into the next one
      write_threshold('0);
      push_frame(PAT_RANDOM, 2 * FW + 90, 80, 1'b0);
      wait_drained();
      write_threshold(THRESHOLD_MAX);
      push_frame(PAT_SPIKY, 2 * FW + 170, 30, 1'b0);
      wait_drained();

      // Restarts at random points, broken rows and stray frame starts
      write_threshold(TW'($urandom_range(1, 400)));
      push_frame(PAT_RANDOM, 0, $urandom_range(20, 100), 1'b1);
      push_noise(40);
      push_frame(PAT_RANDOM, 0, 2 * FW + 60, 1'b1);
      wait_drained();

      // No idling; receiver holds off long enough for the input to stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(TW'(300));
      hold_token++;
      push_frame(PAT_RANDOM, 2 * FW + 60, 100, 1'b0);
      wait_drained();

      $display("Checked %0d edge points from %0d pixel transactions over %0d threshold writes",
               points_checked, pixels_accepted, thresholds_written);
      $display("Covered threshold edges at full strength, borders, restarts and a long hold");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> laplacian_edge_point_detector_core.f
rtl/lepd_pkg.sv
rtl/lepd_ram.sv
rtl/laplacian_edge_point_detector_core.sv
test/tb_laplacian_edge_point_detector_core.sv
